// ===== rtl/core/btmx_pkg.sv =====
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared defaults, command codes and the per-level control struct of the
// binary trie maximum-XOR block.
// ----------------------------------------------------------------------------
package btmx_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int NODE_COUNT_DEF = 4096;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Decision of one trie level
    typedef struct packed {
        logic wr_en;    // write back the current node's child pair
        logic alloc;    // next node is taken from the free pointer
        logic res_bit;  // result bit of this level (queries)
        logic stop;     // no child to follow (queries)
    } t_step_ctl;

endpackage

// ===== rtl/core/binary_trie_max_xor.sv =====
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// Bitwise trie of stored values with maximum-XOR queries.
// ----------------------------------------------------------------------------
// An insert (cmd 0) stores value in the trie; a query (cmd 1) returns the
// largest XOR of value with any stored value. Each request yields exactly one
// result. A request walks the trie from the top bit down, one level per clock,
// reading one node a cycle from the node memory. A walked request passes its
// VALUE_BITS levels in ST_WALK and then loads the output register in
// ST_FINISH; the next request is taken only once the block is back in
// ST_IDLE. A query on an empty trie and a refused insert skip the walk: they
// go straight from ST_IDLE to ST_FINISH, which loads the output register,
// and the next request is taken once the block is back in ST_IDLE. One
// request is in flight at a time; a finished result waits in the output
// register while the next request is accepted and walked, and a later result,
// with the input stalled, is held back until the waiting one is taken. The
// root's child pair lives in flip-flops; other nodes are written when
// allocated, so no memory clearing is needed after reset. An insert is
// refused, and flagged, when fewer than VALUE_BITS nodes remain free.
// ----------------------------------------------------------------------------
module binary_trie_max_xor
    import btmx_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_max_xor,
    output logic        o_trie_empty,
    output logic        o_insert_refused
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int FREE_W = $clog2(NODE_COUNT + 1);
    localparam int LVL_W  = $clog2(VALUE_BITS);
    localparam logic [FREE_W-1:0] FREE_LIMIT = FREE_W'(NODE_COUNT - VALUE_BITS);
    localparam logic [LVL_W-1:0]  LVL_TOP    = LVL_W'(VALUE_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    t_state                r_state;
    logic [FREE_W-1:0]     r_free;
    logic                  r_holds;
    logic [IDX_W-1:0]      r_root0;
    logic [IDX_W-1:0]      r_root1;
    logic [IDX_W-1:0]      r_node;
    logic                  r_at_root;
    logic                  r_fresh;
    logic                  r_stopped;
    logic                  r_query;
    logic [LVL_W-1:0]      r_lvl;
    logic [VALUE_BITS-1:0] r_key;
    logic [VALUE_BITS-1:0] r_res;
    logic                  r_empty;
    logic                  r_refused;
    logic                  r_out_valid;
    logic [31:0]           r_max_xor;
    logic                  r_trie_empty;
    logic                  r_insert_refused;

    logic [2*IDX_W-1:0]    rd_data;
    logic [IDX_W-1:0]      cur0;
    logic [IDX_W-1:0]      cur1;
    logic [IDX_W-1:0]      n_node;
    logic [IDX_W-1:0]      wr0;
    logic [IDX_W-1:0]      wr1;
    t_step_ctl             ctl;
    logic                  in_acc;
    logic                  walking;
    logic                  mem_we;
    logic                  out_free;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign walking  = (r_state == ST_WALK);
    assign out_free = !r_out_valid || !i_out_stall;

    // children of the node at the current level
    always_comb begin
        if (r_at_root) begin
            cur0 = r_root0;
            cur1 = r_root1;
        end else if (r_fresh || r_stopped) begin
            cur0 = '0;
            cur1 = '0;
        end else begin
            cur0 = rd_data[IDX_W-1:0];
            cur1 = rd_data[2*IDX_W-1:IDX_W];
        end
    end

    btmx_step #(
        .IDX_W (IDX_W)
    ) u_step (
        .i_query     (r_query),
        .i_bit       (r_key[VALUE_BITS-1]),
        .i_child0    (cur0),
        .i_child1    (cur1),
        .i_free      (r_free[IDX_W-1:0]),
        .o_next      (n_node),
        .o_wr_child0 (wr0),
        .o_wr_child1 (wr1),
        .o_ctl       (ctl)
    );

    assign mem_we = walking && ctl.wr_en && !r_at_root;

    btmx_ram #(
        .WIDTH (2 * IDX_W),
        .DEPTH (NODE_COUNT)
    ) u_nodes (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_node),
        .i_wr_data ({wr1, wr0}),
        .i_rd_en   (walking),
        .i_rd_addr (n_node),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_free      <= FREE_W'(1);
            r_holds     <= 1'b0;
            r_root0     <= '0;
            r_root1     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the taken result unless a new one is loaded this cycle
            if (r_out_valid && !i_out_stall && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_key     <= VALUE_BITS'(i_value);
                        r_res     <= '0;
                        r_lvl     <= LVL_TOP;
                        r_at_root <= 1'b1;
                        r_fresh   <= 1'b0;
                        r_stopped <= 1'b0;
                        r_query   <= (i_cmd == CMD_QUERY);
                        r_empty   <= 1'b0;
                        r_refused <= 1'b0;
                        if (i_cmd == CMD_QUERY) begin
                            if (!r_holds) begin
                                r_empty <= 1'b1;
                                r_state <= ST_FINISH;
                            end else begin
                                r_state <= ST_WALK;
                            end
                        end else begin
                            if (r_free > FREE_LIMIT) begin
                                r_refused <= 1'b1;
                                r_state   <= ST_FINISH;
                            end else begin
                                r_state <= ST_WALK;
                            end
                        end
                    end
                end
                ST_WALK: begin
                    if (r_at_root && ctl.wr_en) begin
                        r_root0 <= wr0;
                        r_root1 <= wr1;
                    end
                    if (ctl.alloc) begin
                        r_free <= r_free + FREE_W'(1);
                    end
                    r_node    <= n_node;
                    r_at_root <= 1'b0;
                    r_fresh   <= ctl.alloc;
                    r_stopped <= r_stopped || ctl.stop;
                    r_res     <= {r_res[VALUE_BITS-2:0], ctl.res_bit};
                    r_key     <= {r_key[VALUE_BITS-2:0], 1'b0};
                    r_lvl     <= r_lvl - LVL_W'(1);
                    if (r_lvl == '0) begin
                        if (!r_query) begin
                            r_holds <= 1'b1;
                        end
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // hold the result until the output register frees up
                    if (out_free) begin
                        r_out_valid      <= 1'b1;
                        r_max_xor        <= 32'(r_res);
                        r_trie_empty     <= r_empty;
                        r_insert_refused <= r_refused;
                        r_state          <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_max_xor        = r_max_xor;
    assign o_trie_empty     = r_trie_empty;
    assign o_insert_refused = r_insert_refused;

endmodule

// ===== rtl/core/btmx_ram.sv =====
// ----------------------------------------------------------------------------
// btmx_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module btmx_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/btmx_step.sv =====
// ----------------------------------------------------------------------------
// btmx_step
// One trie level: picks the child to follow for an insert or a query,
// allocates a missing child on insert and builds the updated child pair.
// ----------------------------------------------------------------------------
module btmx_step
    import btmx_pkg::*;
#(
    parameter int IDX_W = 12
) (
    input  logic             i_query,
    input  logic             i_bit,
    input  logic [IDX_W-1:0] i_child0,
    input  logic [IDX_W-1:0] i_child1,
    input  logic [IDX_W-1:0] i_free,
    output logic [IDX_W-1:0] o_next,
    output logic [IDX_W-1:0] o_wr_child0,
    output logic [IDX_W-1:0] o_wr_child1,
    output t_step_ctl        o_ctl
);

    logic [IDX_W-1:0] same_child;
    logic [IDX_W-1:0] opp_child;
    logic             same_ok;
    logic             opp_ok;

    assign same_child = i_bit ? i_child1 : i_child0;
    assign opp_child  = i_bit ? i_child0 : i_child1;
    assign same_ok    = (same_child != '0);
    assign opp_ok     = (opp_child != '0);

    always_comb begin
        o_next      = '0;
        o_wr_child0 = i_child0;
        o_wr_child1 = i_child1;
        o_ctl       = '0;
        if (i_query) begin
            if (opp_ok) begin
                o_next        = opp_child;
                o_ctl.res_bit = 1'b1;
            end else if (same_ok) begin
                o_next = same_child;
            end else begin
                o_ctl.stop = 1'b1;
            end
        end else begin
            if (same_ok) begin
                o_next = same_child;
            end else begin
                // hang a fresh node on the missing side
                o_next      = i_free;
                o_ctl.alloc = 1'b1;
                o_ctl.wr_en = 1'b1;
                if (i_bit) begin
                    o_wr_child1 = i_free;
                end else begin
                    o_wr_child0 = i_free;
                end
            end
        end
    end

endmodule
